FILE: rtl/rdsr_pkg.sv
// shared types, constants and helpers for the dead-block stream replacement block
package rdsr_pkg;

    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic CFG_DECAY  = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    localparam logic [1:0]  RRIP_DISTANT = 2'd3;
    localparam logic [1:0]  RRIP_LONG    = 2'd2;
    localparam logic [1:0]  RRIP_NEAR    = 2'd0;
    localparam logic [1:0]  DEAD_LIVE    = 2'd3;
    localparam logic [1:0]  DEAD_FILL    = 2'd1;
    localparam logic [1:0]  REUSE_MAX    = 2'd3;
    localparam logic [1:0]  REUSE_HOT    = 2'd2;
    localparam logic [1:0]  REUSE_INIT   = 2'd1;
    localparam logic [2:0]  CONF_MAX     = 3'd7;
    localparam logic [9:0]  PSEL_MID     = 10'd512;
    localparam logic [9:0]  PSEL_MAX     = 10'd1023;
    localparam logic [22:0] DECAY_INIT   = 23'd5000000;
    localparam logic [2:0]  STREAM_INIT  = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [47:0] phys_addr;
        logic [47:0] prog_counter;
        logic        was_hit;
    } t_in_req;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       victim_valid;
    } t_out_res;

    typedef struct packed {
        logic [1:0] rrip;
        logic [1:0] dead;
        logic [4:0] sig;
    } t_line;

    localparam int LINE_W = $bits(t_line);

    typedef struct packed {
        logic [47:0] prev_addr;
        logic [48:0] prev_stride;
        logic [2:0]  conf;
        logic        mode;
    } t_set;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_EXEC,
        ST_WR,
        ST_DECAY
    } t_state;

    function automatic logic [4:0] pc_hash(input logic [47:0] pc);
        logic [47:0] h;
        h = pc ^ (pc >> 7) ^ (pc >> 13);
        return h[4:0];
    endfunction

endpackage

FILE: rtl/rdsr_ram.sv
// generic simple dual port ram with registered read
module rdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rdsr_victim.sv
// victim choice over one set row, with ageing of the row when no line is distant
module rdsr_victim #(
    parameter int NUM_WAYS = 16
) (
    input  logic [NUM_WAYS*rdsr_pkg::LINE_W-1:0] i_row,
    input  logic                                 i_stream,
    output logic [$clog2(NUM_WAYS)-1:0]          o_way,
    output logic [NUM_WAYS*rdsr_pkg::LINE_W-1:0] o_row
);

    localparam int WW = $clog2(NUM_WAYS);
    localparam int LW = rdsr_pkg::LINE_W;

    rdsr_pkg::t_line  lines [NUM_WAYS];
    logic             found_dead;
    logic [WW-1:0]    dead_way;
    logic [WW-1:0]    top_way;
    logic [1:0]       top;
    logic [1:0]       add;
    logic [NUM_WAYS-1:0] is3, is2, is1;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            lines[w] = rdsr_pkg::t_line'(i_row[w*LW +: LW]);
            is3[w]   = (lines[w].rrip == 2'd3);
            is2[w]   = (lines[w].rrip == 2'd2);
            is1[w]   = (lines[w].rrip == 2'd1);
        end
        top = (|is3) ? 2'd3 : (|is2) ? 2'd2 : (|is1) ? 2'd1 : 2'd0;
        add = rdsr_pkg::RRIP_DISTANT - top;

        // first matching way wins, so scan downward
        found_dead = 1'b0;
        dead_way   = '0;
        top_way    = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (lines[w].dead == 2'd0 && lines[w].rrip == rdsr_pkg::RRIP_DISTANT) begin
                found_dead = 1'b1;
                dead_way   = WW'(w);
            end
            if (lines[w].rrip == top) begin
                top_way = WW'(w);
            end
        end

        o_row = i_row;
        if (!i_stream && found_dead) begin
            o_way = dead_way;
        end else begin
            o_way = top_way;
            for (int w = 0; w < NUM_WAYS; w++) begin
                o_row[w*LW +: LW] = {2'(lines[w].rrip + add), lines[w].dead, lines[w].sig};
            end
        end
    end

endmodule

FILE: rtl/rrip_dead_block_stream_replacement.sv
// top level: rrip replacement with dead-block counters, stream detect and set dueling
//
//  channel | signals                                  | direction
//  in      | i_in_valid, o_in_stall, i_in_data        | request in
//  out     | o_out_valid, i_out_stall, o_out_data     | result out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data | register write
//
// a request passes index fold, row read from the line and set memories, compute and
// write back; the index fold repeats once per wrap of an out of range set or way index.
// reset starts a clearing pass over all NUM_SETS rows of both memories, no request taken.
// a tick that reaches the decay period starts a sweep of the line memory after its
// result (one row read and one row write per set).
// a stalled output holds the block in write back until the result register frees.
module rrip_dead_block_stream_replacement #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int LEADER_GROUPS = 64,
    parameter int REUSE_ENTRIES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rdsr_pkg::t_in_req          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rdsr_pkg::t_out_res         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [22:0]                i_cfg_data
);

    localparam int SW    = $clog2(NUM_SETS);
    localparam int SETW  = (SW > 11) ? SW : 11;
    localparam int WW    = $clog2(NUM_WAYS);
    localparam int WAYW  = (WW > 4) ? WW : 4;
    localparam int LW    = rdsr_pkg::LINE_W;
    localparam int ROW_W = NUM_WAYS * LW;
    localparam int SET_W = $bits(rdsr_pkg::t_set);
    localparam int RW    = $clog2(REUSE_ENTRIES);

    rdsr_pkg::t_state r_state, n_state;

    rdsr_pkg::t_in_req r_in;
    logic [SETW-1:0]   r_set;
    logic [WAYW-1:0]   r_way;
    logic [22:0]       r_decay;
    logic [2:0]        r_stream_lvl;
    logic [9:0]        r_psel;
    logic [4:0]        r_bimodal;
    logic [22:0]       r_tick;
    logic [1:0]        r_reuse [REUSE_ENTRIES];
    logic [SW-1:0]     r_cnt;
    logic              r_phase;
    logic              r_out_valid;
    rdsr_pkg::t_out_res r_out;

    // registered results of the compute cycle
    rdsr_pkg::t_set    r_set_new;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_vic_row;
    logic [WW-1:0]     r_vic_way;
    rdsr_pkg::t_line   r_old_line;
    logic [4:0]        r_sig;
    logic              r_lead_s;
    logic              r_lead_b;

    // memory ports
    logic              line_we, line_re, set_we, set_re;
    logic [SW-1:0]     line_waddr, raddr;
    logic [ROW_W-1:0]  line_wdata, line_rdata;
    logic [SET_W-1:0]  set_wdata, set_rdata;

    logic              set_hi, way_hi, out_free, decay_hit;
    rdsr_pkg::t_set    cur_set;
    logic [48:0]       stride;
    logic              match;
    logic [2:0]        conf_n;
    logic [WW-1:0]     vic_way;
    logic [ROW_W-1:0]  vic_row;
    logic [ROW_W-1:0]  upd_row;
    logic [ROW_W-1:0]  decay_row;
    logic [ROW_W-1:0]  clear_row;
    rdsr_pkg::t_line   new_line;
    rdsr_pkg::t_line   dec_line;
    logic [4:0]        reuse_idx;
    logic [1:0]        reuse_val;
    logic [1:0]        ins;
    logic [22:0]       tick_n;

    function automatic logic is_leader(input logic [SW-1:0] s, input logic off);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < LEADER_GROUPS / 2; i++) begin
            if (s == SW'((i * NUM_SETS) / LEADER_GROUPS + int'(off))) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    rdsr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata),
        .i_re    (line_re),
        .i_raddr (raddr),
        .o_rdata (line_rdata)
    );

    rdsr_ram #(.WIDTH(SET_W), .DEPTH(NUM_SETS)) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (r_set[SW-1:0]),
        .i_wdata (set_wdata),
        .i_re    (set_re),
        .i_raddr (raddr),
        .o_rdata (set_rdata)
    );

    rdsr_victim #(.NUM_WAYS(NUM_WAYS)) u_victim (
        .i_row    (line_rdata),
        .i_stream (cur_set.mode),
        .o_way    (vic_way),
        .o_row    (vic_row)
    );

    // datapath
    always_comb begin
        set_hi   = {1'b0, r_set} >= (SETW + 1)'(NUM_SETS);
        way_hi   = {1'b0, r_way} >= (WAYW + 1)'(NUM_WAYS);
        out_free = !r_out_valid || !i_out_stall;

        cur_set = rdsr_pkg::t_set'(set_rdata);
        stride  = {1'b0, r_in.phys_addr} - {1'b0, cur_set.prev_addr};
        match   = (cur_set.prev_addr != 48'd0) && (stride == cur_set.prev_stride);
        if (match) begin
            conf_n = (cur_set.conf < rdsr_pkg::CONF_MAX) ? cur_set.conf + 3'd1 : cur_set.conf;
        end else begin
            conf_n = (cur_set.conf > 3'd0) ? cur_set.conf - 3'd1 : cur_set.conf;
        end

        // insertion position for a fill
        if (r_set_new.mode) begin
            ins = rdsr_pkg::RRIP_DISTANT;
        end else if (r_lead_s) begin
            ins = rdsr_pkg::RRIP_LONG;
        end else if (r_lead_b) begin
            ins = (r_bimodal == 5'd0) ? rdsr_pkg::RRIP_DISTANT : rdsr_pkg::RRIP_LONG;
        end else begin
            ins = (r_psel >= rdsr_pkg::PSEL_MID) ? rdsr_pkg::RRIP_LONG : rdsr_pkg::RRIP_DISTANT;
        end
        reuse_idx = r_in.was_hit ? r_old_line.sig : r_sig;
        reuse_val = r_reuse[reuse_idx[RW-1:0]];
        if (r_old_line.dead == 2'd0) begin
            ins = rdsr_pkg::RRIP_DISTANT;
        end
        if (reuse_val >= rdsr_pkg::REUSE_HOT) begin
            ins = rdsr_pkg::RRIP_NEAR;
        end

        if (r_in.was_hit) begin
            new_line = '{rrip: rdsr_pkg::RRIP_NEAR, dead: rdsr_pkg::DEAD_LIVE,
                         sig: r_old_line.sig};
        end else begin
            new_line = '{rrip: ins, dead: rdsr_pkg::DEAD_FILL, sig: r_sig};
        end

        dec_line = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            upd_row[w*LW +: LW] = (r_way == WAYW'(w)) ? new_line : r_row[w*LW +: LW];
            dec_line = rdsr_pkg::t_line'(line_rdata[w*LW +: LW]);
            if (dec_line.dead != 2'd0) begin
                dec_line.dead = dec_line.dead - 2'd1;
            end
            decay_row[w*LW +: LW] = dec_line;
            clear_row[w*LW +: LW] = rdsr_pkg::t_line'{rrip: rdsr_pkg::RRIP_DISTANT,
                                                      dead: rdsr_pkg::DEAD_FILL,
                                                      sig: 5'd0};
        end

        tick_n    = r_tick + 23'd1;
        decay_hit = tick_n >= r_decay;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdsr_pkg::ST_CLEAR: begin
                if (r_cnt == SW'(NUM_SETS - 1)) n_state = rdsr_pkg::ST_IDLE;
            end
            rdsr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rdsr_pkg::ST_MOD;
            end
            rdsr_pkg::ST_MOD: begin
                if (!set_hi && !way_hi) n_state = rdsr_pkg::ST_EXEC;
            end
            rdsr_pkg::ST_EXEC: begin
                n_state = rdsr_pkg::ST_WR;
            end
            rdsr_pkg::ST_WR: begin
                if (out_free) begin
                    if (r_in.command == rdsr_pkg::CMD_TICK && decay_hit) begin
                        n_state = rdsr_pkg::ST_DECAY;
                    end else begin
                        n_state = rdsr_pkg::ST_IDLE;
                    end
                end
            end
            rdsr_pkg::ST_DECAY: begin
                if (r_phase && r_cnt == SW'(NUM_SETS - 1)) n_state = rdsr_pkg::ST_IDLE;
            end
            default: n_state = rdsr_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        line_re    = 1'b0;
        set_re     = 1'b0;
        line_we    = 1'b0;
        set_we     = 1'b0;
        raddr      = r_set[SW-1:0];
        line_waddr = r_set[SW-1:0];
        line_wdata = upd_row;
        set_wdata  = r_set_new;
        o_in_stall = 1'b1;
        unique case (r_state)
            rdsr_pkg::ST_CLEAR: begin
                line_we    = 1'b1;
                set_we     = 1'b1;
                line_waddr = r_cnt;
                line_wdata = clear_row;
                set_wdata  = '0;
            end
            rdsr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            rdsr_pkg::ST_MOD: begin
                line_re = !set_hi && !way_hi;
                set_re  = !set_hi && !way_hi;
            end
            rdsr_pkg::ST_EXEC: begin
            end
            rdsr_pkg::ST_WR: begin
                if (out_free) begin
                    case (r_in.command)
                        rdsr_pkg::CMD_VICTIM: begin
                            line_we    = 1'b1;
                            line_wdata = r_vic_row;
                        end
                        rdsr_pkg::CMD_UPDATE: begin
                            line_we = 1'b1;
                            set_we  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rdsr_pkg::ST_DECAY: begin
                raddr      = r_cnt;
                line_re    = !r_phase;
                line_we    = r_phase;
                line_waddr = r_cnt;
                line_wdata = decay_row;
            end
            default: begin
            end
        endcase
    end

    // set memory clearing pass writes at the sweep counter
    // (set ram address is r_set, so it is pointed at the counter during clear)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rdsr_pkg::ST_CLEAR;
            r_cnt        <= '0;
            r_phase      <= 1'b0;
            r_decay      <= rdsr_pkg::DECAY_INIT;
            r_stream_lvl <= rdsr_pkg::STREAM_INIT;
            r_psel       <= rdsr_pkg::PSEL_MID;
            r_bimodal    <= 5'd0;
            r_tick       <= 23'd0;
            r_out_valid  <= 1'b0;
            r_set        <= '0;
            for (int i = 0; i < REUSE_ENTRIES; i++) begin
                r_reuse[i] <= rdsr_pkg::REUSE_INIT;
            end
        end else begin
            r_state <= n_state;
            if (r_state == rdsr_pkg::ST_WR && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rdsr_pkg::CFG_DECAY:  r_decay      <= i_cfg_data;
                    rdsr_pkg::CFG_STREAM: r_stream_lvl <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                rdsr_pkg::ST_CLEAR: begin
                    r_cnt <= (r_cnt == SW'(NUM_SETS - 1)) ? '0 : r_cnt + SW'(1);
                    r_set <= SETW'(r_cnt + SW'(1));
                end
                rdsr_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_in  <= i_in_data;
                        r_set <= SETW'(i_in_data.set_index);
                        r_way <= WAYW'(i_in_data.way_index);
                    end
                end
                rdsr_pkg::ST_MOD: begin
                    if (set_hi) r_set <= r_set - SETW'(NUM_SETS);
                    if (way_hi) r_way <= r_way - WAYW'(NUM_WAYS);
                end
                rdsr_pkg::ST_EXEC: begin
                    r_set_new  <= '{prev_addr: r_in.phys_addr, prev_stride: stride,
                                    conf: conf_n, mode: conf_n >= r_stream_lvl};
                    r_row      <= line_rdata;
                    r_vic_row  <= vic_row;
                    r_vic_way  <= vic_way;
                    r_old_line <= rdsr_pkg::t_line'(line_rdata[r_way[WW-1:0]*LW +: LW]);
                    r_sig      <= rdsr_pkg::pc_hash(r_in.prog_counter);
                    r_lead_s   <= is_leader(r_set[SW-1:0], 1'b0);
                    r_lead_b   <= is_leader(r_set[SW-1:0], 1'b1);
                end
                rdsr_pkg::ST_WR: begin
                    if (out_free) begin
                        r_out.victim_way   <= (r_in.command == rdsr_pkg::CMD_VICTIM) ?
                                              4'(r_vic_way) : 4'd0;
                        r_out.victim_valid <= (r_in.command == rdsr_pkg::CMD_VICTIM);
                        case (r_in.command)
                            rdsr_pkg::CMD_UPDATE: begin
                                if (r_in.was_hit) begin
                                    if (reuse_val < rdsr_pkg::REUSE_MAX) begin
                                        r_reuse[reuse_idx[RW-1:0]] <= reuse_val + 2'd1;
                                    end
                                    if (r_lead_s && r_psel < rdsr_pkg::PSEL_MAX) begin
                                        r_psel <= r_psel + 10'd1;
                                    end
                                    if (r_lead_b && r_psel > 10'd0) begin
                                        r_psel <= r_psel - 10'd1;
                                    end
                                end else begin
                                    if (reuse_val > 2'd0) begin
                                        r_reuse[reuse_idx[RW-1:0]] <= reuse_val - 2'd1;
                                    end
                                    if (!r_set_new.mode && !r_lead_s && r_lead_b) begin
                                        r_bimodal <= r_bimodal + 5'd1;
                                    end
                                    if (r_lead_s && r_psel > 10'd0) begin
                                        r_psel <= r_psel - 10'd1;
                                    end
                                    if (r_lead_b && r_psel < rdsr_pkg::PSEL_MAX) begin
                                        r_psel <= r_psel + 10'd1;
                                    end
                                end
                            end
                            rdsr_pkg::CMD_TICK: begin
                                r_tick  <= decay_hit ? 23'd0 : tick_n;
                                r_cnt   <= '0;
                                r_phase <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                rdsr_pkg::ST_DECAY: begin
                    r_phase <= !r_phase;
                    if (r_phase) r_cnt <= r_cnt + SW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: bench/rrip_dead_block_stream_replacement_test.sv
// self-checking bench for the dead-block stream replacement block
module rrip_dead_block_stream_replacement_test;
    import rdsr_pkg::*;

    localparam int SETS       = 2048;
    localparam int WAYS       = 16;
    localparam int LEADERS    = 64;
    localparam int LINES      = SETS * WAYS;
    localparam int SWEEP_WAIT = 2 * SETS + 200;
    localparam int STALL_MAX  = 20000;
    localparam int PER_PHASE  = 310;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_res    o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [22:0] i_cfg_data;

    rrip_dead_block_stream_replacement DUT (.*);

    // model of the replacement state
    logic [1:0]  m_rrip [LINES];
    logic [1:0]  m_dead [LINES];
    logic [4:0]  m_sig [LINES];
    logic [1:0]  m_reuse [32];
    logic [47:0] m_prev_addr [SETS];
    logic [48:0] m_prev_stride [SETS];
    logic [2:0]  m_conf [SETS];
    logic        m_mode [SETS];
    logic [9:0]  m_psel;
    logic [4:0]  m_bimodal;
    logic [22:0] m_ticks;
    logic [22:0] m_decay_period;
    logic [2:0]  m_stream_level;

    t_in_req  pending_reqs[$];
    t_out_res expected_results[$];
    bit       in_took;
    bit       running;
    int       idle_pct;
    int       stall_pct;
    int       errors;
    int       n_results;
    int       n_ticks;
    int       n_victims;
    int       quiet_cycles;

    // stimulus helpers
    logic [47:0] strm_addr [SETS];
    logic [47:0] strm_step [SETS];
    logic [47:0] pc_pool [4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit srrip_leader(input int s);
        for (int i = 0; i < LEADERS / 2; i++)
            if (i * SETS / LEADERS == s) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit brrip_leader(input int s);
        for (int i = 0; i < LEADERS / 2; i++)
            if (i * SETS / LEADERS + 1 == s) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [3:0] pick_victim(input int s);
        int          base;
        logic [1:0]  top;
        base = s * WAYS;
        top  = 2'd0;
        if (!m_mode[s]) begin
            for (int w = 0; w < WAYS; w++)
                if (m_dead[base + w] == 2'd0 && m_rrip[base + w] == RRIP_DISTANT) return w[3:0];
        end
        for (int w = 0; w < WAYS; w++)
            if (m_rrip[base + w] > top) top = m_rrip[base + w];
        // age the whole set until some line is distant
        if (top < RRIP_DISTANT)
            for (int w = 0; w < WAYS; w++)
                m_rrip[base + w] = m_rrip[base + w] + (RRIP_DISTANT - top);
        for (int w = 0; w < WAYS; w++)
            if (m_rrip[base + w] == RRIP_DISTANT) return w[3:0];
        return 4'd0;
    endfunction

    function automatic void apply_access(input t_in_req r);
        int          s;
        int          line;
        logic [48:0] stride;
        logic [47:0] h;
        logic [4:0]  sg;
        logic [4:0]  old;
        logic [1:0]  ins;
        bit          ls;
        bit          lb;
        s      = r.set_index;
        line   = s * WAYS + r.way_index;
        stride = {1'b0, r.phys_addr} - {1'b0, m_prev_addr[s]};
        ls     = srrip_leader(s);
        lb     = brrip_leader(s);
        h      = r.prog_counter ^ (r.prog_counter >> 7) ^ (r.prog_counter >> 13);
        sg     = h[4:0];
        if (m_prev_addr[s] != 48'd0 && stride == m_prev_stride[s]) begin
            if (m_conf[s] < CONF_MAX) m_conf[s]++;
        end else if (m_conf[s] > 3'd0) begin
            m_conf[s]--;
        end
        m_prev_addr[s]   = r.phys_addr;
        m_prev_stride[s] = stride;
        m_mode[s]        = (m_conf[s] >= m_stream_level);
        if (r.was_hit) begin
            old          = m_sig[line];
            m_rrip[line] = RRIP_NEAR;
            m_dead[line] = DEAD_LIVE;
            if (m_reuse[old] < REUSE_MAX) m_reuse[old]++;
            if (ls && m_psel < PSEL_MAX) m_psel++;
            if (lb && m_psel > 10'd0) m_psel--;
            return;
        end
        if (m_mode[s]) begin
            ins = RRIP_DISTANT;
        end else if (ls) begin
            ins = RRIP_LONG;
        end else if (lb) begin
            ins = (m_bimodal == 5'd0) ? RRIP_DISTANT : RRIP_LONG;
            m_bimodal++;
        end else begin
            ins = (m_psel >= PSEL_MID) ? RRIP_LONG : RRIP_DISTANT;
        end
        if (m_dead[line] == 2'd0) ins = RRIP_DISTANT;
        if (m_reuse[sg] >= REUSE_HOT) ins = RRIP_NEAR;
        m_sig[line]  = sg;
        m_rrip[line] = ins;
        m_dead[line] = DEAD_FILL;
        if (m_reuse[sg] > 2'd0) m_reuse[sg]--;
        if (ls && m_psel > 10'd0) m_psel--;
        if (lb && m_psel < PSEL_MAX) m_psel++;
    endfunction

    function automatic t_out_res predict_result(input t_in_req r);
        t_out_res res;
        res = '0;
        case (r.command)
            CMD_VICTIM: begin
                res.victim_way   = pick_victim(r.set_index);
                res.victim_valid = 1'b1;
                n_victims++;
            end
            CMD_UPDATE: apply_access(r);
            CMD_TICK: begin
                n_ticks++;
                m_ticks++;
                if (m_ticks >= m_decay_period) begin
                    m_ticks = '0;
                    for (int i = 0; i < LINES; i++)
                        if (m_dead[i] > 2'd0) m_dead[i]--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic t_in_req mk_req(input logic [1:0] cmd, input int s, input int w,
                                       input logic [47:0] a, input logic [47:0] pc,
                                       input bit hit);
        t_in_req r;
        r.command      = cmd;
        r.set_index    = s[10:0];
        r.way_index    = w[3:0];
        r.phys_addr    = a;
        r.prog_counter = pc;
        r.was_hit      = hit;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic int pick_set();
        int pool [10] = '{0, 1, 64, 65, 128, 129, 3, 7, 100, 2047};
        if ($urandom_range(99) < 10) return $urandom_range(SETS - 1);
        return pool[$urandom_range(9)];
    endfunction

    function automatic t_in_req random_req();
        int          k;
        int          s;
        logic [47:0] pc;
        k  = $urandom_range(99);
        s  = pick_set();
        pc = ($urandom_range(99) < 80) ? pc_pool[$urandom_range(3)] : rand48();
        if (k < 35) return mk_req(CMD_VICTIM, s, $urandom_range(15), rand48(), rand48(),
                                  1'($urandom_range(1)));
        if (k < 80) begin
            // stride stream into one set, occasionally breaking the pattern
            if ($urandom_range(9) == 0) strm_step[s] = 48'($urandom_range(1, 512) * 64);
            strm_addr[s] = strm_addr[s] + strm_step[s];
            return mk_req(CMD_UPDATE, s, $urandom_range(15), strm_addr[s], pc,
                          1'($urandom_range(1)));
        end
        if (k < 93) return mk_req(CMD_UPDATE, s, $urandom_range(15), rand48(), pc,
                                  1'($urandom_range(1)));
        if (k < 97) return mk_req(CMD_TICK, s, $urandom_range(15), rand48(), pc,
                                  1'($urandom_range(1)));
        return mk_req(CMD_NONE, s, $urandom_range(15), rand48(), rand48(),
                      1'($urandom_range(1)));
    endfunction

    task automatic write_reg(input logic idx, input logic [22:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DECAY) m_decay_period = val;
        else m_stream_level = val[2:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (SWEEP_WAIT) @(negedge i_clk);
    endtask

    // request driver and stall generator
    always @(negedge i_clk) begin
        if (running) begin
            if (!i_in_valid || in_took) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_data  <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // prediction, result checking and watchdog
    always @(posedge i_clk) begin
        t_out_res want;
        in_took = i_in_valid && !o_in_stall && i_rst_n;
        if (in_took) expected_results.push_back(predict_result(i_in_data));
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, victim_way", o_out_data.victim_way, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.victim_way !== want.victim_way)
                    report_mismatch("victim_way", o_out_data.victim_way, want.victim_way);
                if (o_out_data.victim_valid !== want.victim_valid)
                    report_mismatch("victim_valid", o_out_data.victim_valid,
                                    want.victim_valid);
            end
        end
        if (in_took || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("timeout: no handshake for %0d cycles", STALL_MAX);
            $display("rrip_dead_block_stream_replacement regression: fail");
            $finish;
        end
    end

    initial begin
        int          idle_tab  [4] = '{0, 86, 0, 16};
        int          stall_tab [4] = '{0, 0, 86, 16};
        logic [22:0] decay_tab [4] = '{23'd1, 23'd8388607, 23'd3, 23'd0};
        logic [2:0]  level_tab [4] = '{3'd0, 3'd7, 3'd5, 3'd2};
        logic [47:0] ones;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DECAY;
        i_cfg_data  = '0;
        ones        = '1;
        foreach (m_rrip[i]) begin
            m_rrip[i] = RRIP_DISTANT;
            m_dead[i] = DEAD_FILL;
            m_sig[i]  = '0;
        end
        foreach (m_reuse[i]) m_reuse[i] = REUSE_INIT;
        foreach (m_prev_addr[i]) begin
            m_prev_addr[i]   = '0;
            m_prev_stride[i] = '0;
            m_conf[i]        = '0;
            m_mode[i]        = 1'b0;
            strm_addr[i]     = rand48() & 48'hffff_ffff_f000;
            strm_step[i]     = 48'd64;
        end
        foreach (pc_pool[i]) pc_pool[i] = rand48();
        m_psel         = PSEL_MID;
        m_bimodal      = '0;
        m_ticks        = '0;
        m_decay_period = DECAY_INIT;
        m_stream_level = STREAM_INIT;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        // directed: defaults first, a lowered period, then each corner
        pending_reqs.push_back(mk_req(CMD_VICTIM, 0, 0, '0, '0, 1'b0));
        pending_reqs.push_back(mk_req(CMD_TICK, 5, 3, '0, '0, 1'b0));
        pending_reqs.push_back(mk_req(CMD_TICK, 5, 3, '0, '0, 1'b0));
        wait_drained();
        for (int p = 0; p < 4; p++) begin
            if (p != 0) wait_drained();
            write_reg(CFG_DECAY, decay_tab[p]);
            write_reg(CFG_STREAM, level_tab[p]);
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p == 0) begin
                pending_reqs.push_back(mk_req(CMD_UPDATE, 0, 0, ones, ones, 1'b0));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 0, 0, 48'd0, '0, 1'b1));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 1, 15, 48'h40, 48'h1, 1'b0));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 1, 14, 48'h80, 48'h1, 1'b0));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 1, 13, 48'hc0, 48'h1, 1'b0));
                pending_reqs.push_back(mk_req(CMD_VICTIM, 1, 0, '0, '0, 1'b0));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 2047, 15, ones, ones, 1'b1));
                pending_reqs.push_back(mk_req(CMD_UPDATE, 7, 2, 48'h1000, ones, 1'b0));
                pending_reqs.push_back(mk_req(CMD_VICTIM, 7, 0, '0, '0, 1'b0));
                pending_reqs.push_back(mk_req(CMD_NONE, 2047, 15, ones, ones, 1'b1));
                pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, '0, '0, 1'b0));
                pending_reqs.push_back(mk_req(CMD_VICTIM, 2047, 15, ones, ones, 1'b1));
                pending_reqs.push_back(mk_req(CMD_VICTIM, 0, 0, '0, '0, 1'b0));
                // a fully hit set forces ageing on the next victim request
                for (int w = 0; w < WAYS; w++)
                    pending_reqs.push_back(mk_req(CMD_UPDATE, 3, w, rand48(), rand48(), 1'b1));
                pending_reqs.push_back(mk_req(CMD_VICTIM, 3, 0, '0, '0, 1'b0));
            end
            for (int n = 0; n < PER_PHASE; n++) pending_reqs.push_back(random_req());
        end
        wait_drained();
        $display("covered %0d results: %0d victim requests, %0d heartbeat ticks",
                 n_results, n_victims, n_ticks);
        $display("four idle/stall mixes, decay periods 0..8388607, stream levels 0..7");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("rrip_dead_block_stream_replacement regression: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors,
                     expected_results.size());
            $display("rrip_dead_block_stream_replacement regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/rdsr_pkg.sv
rtl/rdsr_ram.sv
rtl/rdsr_victim.sv
rtl/rrip_dead_block_stream_replacement.sv
bench/rrip_dead_block_stream_replacement_test.sv
